// ----- src/stma_pkg.sv -----
// Package for the sparse triplet merge-add block.
// Holds sizes, result status codes, register indexes, the controller state type
// and the command/status structs shared by the controller and the datapath.
`default_nettype none
package stma_pkg;

  localparam int MAX_TERMS  = 32;
  localparam int MAX_DIM    = 256;
  localparam int DIM_CAP    = (MAX_DIM < 256) ? MAX_DIM : 256;

  localparam int DIM_W      = 9;
  localparam int POS_W      = 8;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = VAL_W + 1;
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int TCNT_W     = 7;
  localparam int ENTRY_W    = 2 * POS_W + VAL_W;
  localparam int STAT_W     = 2;
  localparam int ADDR_W     = 4;
  localparam int OUT_DATA_W = 56;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_TERM  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

  // Register indexes (word address bits).
  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CHECK = 3'b010,
    ST_MERGE = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic in_take;
    logic merge_step;
    logic emit_single;
    logic clear_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic size_err;
    logic ovf;
    logic empty;
    logic merge_last;
    logic out_free;
  } dp_stat_t;

  // A size of zero acts as one; sizes above the cap are clamped.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_CAP)) begin
      r = DIM_W'(DIM_CAP);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/stma_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module stma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/stma_ctrl.sv -----
// Controller state machine: load, check (size mismatch, overflow, empty), merge.
// Depends on stma_pkg for the state type and the command/status structs.
`default_nettype none
module stma_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_sel,
  input  wire logic               in_last,
  output logic                    in_tready,
  input  wire stma_pkg::dp_stat_t stat,
  output stma_pkg::ctrl_cmd_t     cmd
);
  import stma_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    cmd             = '0;
    case (state_r)
      ST_LOAD: begin
        in_tready   = 1'b1;
        cmd.in_take = in_tvalid;
        if (in_tvalid && in_last && in_sel) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.size_err || stat.ovf || stat.empty) begin
          if (stat.out_free) begin
            cmd.emit_single = 1'b1;
            cmd.clear_run   = 1'b1;
            state_nxt       = ST_LOAD;
          end
        end else begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (stat.out_free) begin
          cmd.merge_step = 1'b1;
          if (stat.merge_last) begin
            cmd.clear_run = 1'b1;
            state_nxt     = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/stma_dp.sv -----
// Datapath: position counter, triplet lists, merge compare/add and result register.
// Depends on stma_pkg and stma_ram.
`default_nettype none
module stma_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire stma_pkg::ctrl_cmd_t               cmd,
  output stma_pkg::dp_stat_t                     stat,
  input  wire logic [stma_pkg::DIM_W-1:0]        rows_a,
  input  wire logic [stma_pkg::DIM_W-1:0]        cols_a,
  input  wire logic [stma_pkg::DIM_W-1:0]        rows_b,
  input  wire logic [stma_pkg::DIM_W-1:0]        cols_b,
  input  wire logic                              in_sel,
  input  wire logic [stma_pkg::VAL_W-1:0]        in_value,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [stma_pkg::POS_W-1:0]             out_row,
  output logic [stma_pkg::POS_W-1:0]             out_col,
  output logic signed [stma_pkg::SUM_W-1:0]      out_sum,
  output logic [stma_pkg::STAT_W-1:0]            out_status,
  output logic [stma_pkg::TCNT_W-1:0]            out_count,
  output logic                                   out_last
);
  import stma_pkg::*;

  logic [DIM_W-1:0] e_rows_a, e_cols_a, e_rows_b, e_cols_b, sel_rows, sel_cols;
  logic [POS_W-1:0] load_row_r, load_row_nxt, load_col_r, load_col_nxt;
  logic             pos_full_r, pos_full_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic [CNT_W-1:0] count_a_r, count_a_nxt, count_b_r, count_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] ia_r, ia_nxt, jb_r, jb_nxt;
  logic [TCNT_W-1:0] n_r, n_nxt;
  logic             nonzero, store_ok;
  logic             we_a, we_b;
  logic [ENTRY_W-1:0] wentry, ra, rb;
  logic             a_has, b_has, a_lt, b_lt, take_a, take_b, inc_a, inc_b;
  logic [CNT_W-1:0] ia_inc, jb_inc;
  logic [2*POS_W-1:0] key_a, key_b;
  logic signed [SUM_W-1:0] sext_a, sext_b, merge_sum;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [STAT_W-1:0] out_status_r, single_status;
  logic [TCNT_W-1:0] out_count_r;
  logic             out_last_r;

  assign e_rows_a = eff_dim(rows_a);
  assign e_cols_a = eff_dim(cols_a);
  assign e_rows_b = eff_dim(rows_b);
  assign e_cols_b = eff_dim(cols_b);
  assign sel_rows = in_sel ? e_rows_b : e_rows_a;
  assign sel_cols = in_sel ? e_cols_b : e_cols_a;

  // Element load: position stepping and list writes.
  assign nonzero  = (in_value != '0);
  assign store_ok = cmd.in_take && !pos_full_r && nonzero;
  assign we_a     = store_ok && !in_sel && (count_a_r < CNT_W'(MAX_TERMS));
  assign we_b     = store_ok &&  in_sel && (count_b_r < CNT_W'(MAX_TERMS));
  assign wentry   = {load_row_r, load_col_r, in_value};
  assign col_inc  = {1'b0, load_col_r} + DIM_W'(1);
  assign row_inc  = {1'b0, load_row_r} + DIM_W'(1);

  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    pos_full_nxt = pos_full_r;
    if (cmd.in_take) begin
      if (!pos_full_r) begin
        if (col_inc >= sel_cols) begin
          load_col_nxt = '0;
          if (row_inc >= sel_rows) begin
            load_row_nxt = '0;
            pos_full_nxt = 1'b1;
          end else begin
            load_row_nxt = row_inc[POS_W-1:0];
          end
        end else begin
          load_col_nxt = col_inc[POS_W-1:0];
        end
      end
      if (in_last) begin
        load_row_nxt = '0;
        load_col_nxt = '0;
        pos_full_nxt = 1'b0;
      end
    end
  end

  // Merge compare and add over the current heads of both lists.
  assign a_has  = (ia_r < count_a_r);
  assign b_has  = (jb_r < count_b_r);
  assign key_a  = ra[ENTRY_W-1:VAL_W];
  assign key_b  = rb[ENTRY_W-1:VAL_W];
  assign a_lt   = key_a < key_b;
  assign b_lt   = key_b < key_a;
  assign take_a = a_has && (!b_has || a_lt);
  assign take_b = b_has && (!a_has || b_lt);
  assign inc_a  = a_has && !take_b;
  assign inc_b  = b_has && !take_a;
  assign ia_inc = ia_r + CNT_W'(inc_a);
  assign jb_inc = jb_r + CNT_W'(inc_b);
  assign sext_a = {ra[VAL_W-1], ra[VAL_W-1:0]};
  assign sext_b = {rb[VAL_W-1], rb[VAL_W-1:0]};

  always_comb begin
    if (take_a) begin
      merge_sum = sext_a;
    end else if (take_b) begin
      merge_sum = sext_b;
    end else begin
      merge_sum = sext_a + sext_b;
    end
  end

  always_comb begin
    count_a_nxt = count_a_r + CNT_W'(we_a);
    count_b_nxt = count_b_r + CNT_W'(we_b);
    ovf_nxt     = ovf_r || (store_ok && !we_a && !we_b);
    ia_nxt      = cmd.merge_step ? ia_inc : ia_r;
    jb_nxt      = cmd.merge_step ? jb_inc : jb_r;
    n_nxt       = cmd.merge_step ? n_r + TCNT_W'(1) : n_r;
    if (cmd.clear_run) begin
      count_a_nxt = '0;
      count_b_nxt = '0;
      ovf_nxt     = 1'b0;
      ia_nxt      = '0;
      jb_nxt      = '0;
      n_nxt       = '0;
    end
  end

  // Read addresses follow the next index so that read data matches the index register.
  stma_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TERMS)) u_list_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a_r[IDX_W-1:0]),
    .wdata (wentry),
    .raddr (ia_nxt[IDX_W-1:0]),
    .rdata (ra)
  );

  stma_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TERMS)) u_list_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b_r[IDX_W-1:0]),
    .wdata (wentry),
    .raddr (jb_nxt[IDX_W-1:0]),
    .rdata (rb)
  );

  always_comb begin
    if (stat.size_err) begin
      single_status = STAT_SIZE;
    end else if (ovf_r) begin
      single_status = STAT_OVF;
    end else begin
      single_status = STAT_EMPTY;
    end
  end

  assign stat.size_err   = (e_rows_a != e_rows_b) || (e_cols_a != e_cols_b);
  assign stat.ovf        = ovf_r;
  assign stat.empty      = (count_a_r == '0) && (count_b_r == '0);
  assign stat.merge_last = (ia_inc >= count_a_r) && (jb_inc >= count_b_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_single || cmd.merge_step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r  <= '0;
      load_col_r  <= '0;
      pos_full_r  <= 1'b0;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      ia_r        <= '0;
      jb_r        <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_row_r  <= load_row_nxt;
      load_col_r  <= load_col_nxt;
      pos_full_r  <= pos_full_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ovf_r       <= ovf_nxt;
      ia_r        <= ia_nxt;
      jb_r        <= jb_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_sum_r    <= '0;
      out_status_r <= single_status;
      out_count_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.merge_step) begin
      out_row_r    <= take_a ? ra[ENTRY_W-1:ENTRY_W-POS_W] : rb[ENTRY_W-1:ENTRY_W-POS_W];
      out_col_r    <= take_a ? ra[VAL_W+POS_W-1:VAL_W] : rb[VAL_W+POS_W-1:VAL_W];
      out_sum_r    <= merge_sum;
      out_status_r <= STAT_TERM;
      out_count_r  <= stat.merge_last ? n_r + TCNT_W'(1) : '0;
      out_last_r   <= stat.merge_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_sum    = out_sum_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= CNT_W'(MAX_TERMS)) && (count_b_r <= CNT_W'(MAX_TERMS)))
    else $error("list count above capacity");

  a_merge_has_term: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> (a_has || b_has))
    else $error("merge step with both lists exhausted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.merge_step || cmd.emit_single))
    else $error("pending result overwritten");

  a_no_load_in_merge: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge_step |-> !(we_a || we_b))
    else $error("list written during merge");

endmodule
`default_nettype wire

// ----- src/sparse_triplet_merge_add.sv -----
// Sparse triplet merge-add, top level: configuration registers, controller, datapath.
// Elements are taken one per cycle while loading; after the last element of B the
// check state runs, then one result per cycle while the output is not stalled
// (output register, one merge step per cycle through the registered list reads).
// Synchronous active-low reset clears all control state and sets sizes to 1x1.
// Depends on stma_pkg, stma_ctrl, stma_dp and stma_ram.
`default_nettype none
module sparse_triplet_merge_add (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [stma_pkg::VAL_W-1:0]          in_tdata,   // elem_value
  input  wire logic                                in_tuser,   // matrix_sel
  input  wire logic                                in_tlast,   // elem_last
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_row[7:0], out_col[15:8], out_sum[48:16], term_count[55:49]
  output logic [stma_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic [stma_pkg::STAT_W-1:0]              out_tuser,  // status
  output logic                                     out_tlast,  // out_last
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [stma_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);
  import stma_pkg::*;

  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [POS_W-1:0] res_row, res_col;
  logic signed [SUM_W-1:0] res_sum;
  logic [TCNT_W-1:0] res_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      rows_b_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROWS_A: rows_a_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS_A: cols_a_r <= cfg_pwdata[DIM_W-1:0];
        REG_ROWS_B: rows_b_r <= cfg_pwdata[DIM_W-1:0];
        REG_COLS_B: cols_b_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_A: cfg_prdata = 32'(rows_a_r);
      REG_COLS_A: cfg_prdata = 32'(cols_a_r);
      REG_ROWS_B: cfg_prdata = 32'(rows_b_r);
      REG_COLS_B: cfg_prdata = 32'(cols_b_r);
      default:    cfg_prdata = '0;
    endcase
  end

  stma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_sel    (in_tuser),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stma_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .rows_a     (rows_a_r),
    .cols_a     (cols_a_r),
    .rows_b     (rows_b_r),
    .cols_b     (cols_b_r),
    .in_sel     (in_tuser),
    .in_value   (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_row    (res_row),
    .out_col    (res_col),
    .out_sum    (res_sum),
    .out_status (out_tuser),
    .out_count  (res_count),
    .out_last   (out_tlast)
  );

  assign out_tdata = {res_count, res_sum, res_col, res_row};

endmodule
`default_nettype wire
